[design/prr_pkg.sv]
// ----------------------------------------------------------------------------
// prr_pkg
// Shared constants, register codes and control structures of the polyphase
// rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_UP             = 16;
    localparam int DEF_MAX_TAPS_PER_PHASE = 32;
    localparam int DEF_COEF_DEPTH         = 512;
    localparam int DEF_SAMPLE_WIDTH       = 16;

    // Fixed field and register widths.
    localparam int CIDX_W     = 9;
    localparam int UP_REG_W   = 5;
    localparam int DOWN_REG_W = 5;
    localparam int TAPS_REG_W = 6;
    localparam int DEC_W      = 4;
    localparam int MAX_DOWN   = 16;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_UP_FACTOR   = 2'd0,
        REG_DOWN_FACTOR = 2'd1,
        REG_TAPS        = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    // Input word kinds carried on tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;      // zero one coefficient entry of the clearing pass
        logic load;       // write one coefficient
        logic sample;     // latch a sample and start the pointer update
        logic mod_sub;    // one subtract step of the pointer wrap
        logic commit;     // write the delay line, pointer and decimation count
        logic addr_load;  // load the tap address generators for a new result
        logic issue;      // issue one tap into the MAC pipeline
        logic first;      // first tap of a result
        logic last_tap;   // last tap of a result
        logic last_res;   // tap belongs to the last result of a run
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;   // clearing pass at its final entry
        logic mod_ge;       // pointer sum still at or above the length
        logic dec_zero;     // decimation count is zero
        logic out_free;     // output register empty
        logic result_done;  // a result is loaded into the output register
    } stat_t;

    // Flags that travel along the MAC pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last_tap;
        logic last_res;
    } pipe_t;

endpackage

[design/polyphase_rational_resampler_unit.sv]
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_unit
// Polyphase FIR rational sample rate converter: interpolate by up_factor,
// decimate by down_factor, with coefficients loaded over the input stream.
// ----------------------------------------------------------------------------
// After reset the block zeroes all COEF_DEPTH entries (512 by default) of the
// coefficient memory and accepts no input word meanwhile; register writes are
// taken throughout. A load word (tuser high) writes one coefficient. A sample
// word is followed by one subtraction for each step that brings the delay
// pointer back into range: one whenever the pointer is not at zero, and more
// after a shortening of taps_per_phase. A kept sample then produces
// up_factor results, each computed by one shared multiply-accumulate that
// runs one tap per cycle; a result starts only once the output register is
// empty, so m_tready can hold the run. The next input word is taken once the
// last result of the run sits in the output register.
module polyphase_rational_resampler_unit import prr_pkg::*;
#(
    parameter int MAX_UP             = DEF_MAX_UP,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS_PER_PHASE,
    parameter int COEF_DEPTH         = DEF_COEF_DEPTH,
    parameter int SAMPLE_WIDTH       = DEF_SAMPLE_WIDTH,
    localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + CIDX_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata from bit 0: sample_in, coef_index, coef_value, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // tuser: opcode (0 = sample, 1 = coefficient load)
    input  logic                   s_tuser,

    // Output stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata from bit 0: sample_out, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,

    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int UP_W   = $clog2(MAX_UP + 1);
    localparam int TAPS_W = $clog2(MAX_TAPS_PER_PHASE + 1);
    localparam int JW     = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;

    logic [UP_W-1:0]         up_eff;
    logic [DOWN_REG_W-1:0]   down_eff;
    logic [TAPS_W-1:0]       taps_eff;
    cmd_t                    cmd;
    stat_t                   stat;
    logic [JW-1:0]           j_idx;
    logic signed [SW-1:0]    sample_in;
    logic [CIDX_W-1:0]       coef_index;
    logic signed [SW-1:0]    coef_value;
    logic [SW-1:0]           sample_out;

    // Unpack the input word.
    assign sample_in  = s_tdata[SW-1:0];
    assign coef_index = s_tdata[SW +: CIDX_W];
    assign coef_value = s_tdata[SW + CIDX_W +: SW];

    assign m_tdata = OUT_TDATA_W'(sample_out);

    prr_regs #(
        .MAX_UP             (MAX_UP),
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .up_eff   (up_eff),
        .down_eff (down_eff),
        .taps_eff (taps_eff)
    );

    prr_ctrl #(
        .MAX_UP             (MAX_UP),
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .s_tready (s_tready),
        .up_eff   (up_eff),
        .taps_eff (taps_eff),
        .stat     (stat),
        .cmd      (cmd),
        .j_idx    (j_idx)
    );

    prr_dp #(
        .MAX_UP             (MAX_UP),
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE),
        .COEF_DEPTH         (COEF_DEPTH),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .j_idx       (j_idx),
        .up_eff      (up_eff),
        .down_eff    (down_eff),
        .taps_eff    (taps_eff),
        .sample_in   (sample_in),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .sample_out  (sample_out),
        .last_of_run (m_tlast)
    );

endmodule

[design/prr_regs.sv]
// ----------------------------------------------------------------------------
// prr_regs
// Configuration registers behind the APB-style port, with the effective
// (clamped) values used by the controller and datapath.
// ----------------------------------------------------------------------------
module prr_regs import prr_pkg::*;
#(
    parameter int MAX_UP             = DEF_MAX_UP,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS_PER_PHASE,
    localparam int UP_W   = $clog2(MAX_UP + 1),
    localparam int TAPS_W = $clog2(MAX_TAPS_PER_PHASE + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [UP_W-1:0]       up_eff,
    output logic [DOWN_REG_W-1:0] down_eff,
    output logic [TAPS_W-1:0]     taps_eff
);

    logic [UP_REG_W-1:0]   up_reg;
    logic [DOWN_REG_W-1:0] down_reg;
    logic [TAPS_REG_W-1:0] taps_reg;
    reg_idx_t              reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; an address past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= UP_REG_W'(1);
            down_reg <= DOWN_REG_W'(1);
            taps_reg <= TAPS_REG_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_UP_FACTOR:   up_reg   <= pwdata[UP_REG_W-1:0];
                REG_DOWN_FACTOR: down_reg <= pwdata[DOWN_REG_W-1:0];
                REG_TAPS:        taps_reg <= pwdata[TAPS_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read back of the raw register values.
    always_comb
    begin
        unique case (reg_idx)
            REG_UP_FACTOR:   prdata = PDATA_W'(up_reg);
            REG_DOWN_FACTOR: prdata = PDATA_W'(down_reg);
            REG_TAPS:        prdata = PDATA_W'(taps_reg);
            default:         prdata = '0;
        endcase
    end

    // A zero acts as one and a value above the maximum acts as the maximum.
    always_comb
    begin
        priority if (up_reg == '0)
            up_eff = UP_W'(1);
        else if (32'(up_reg) > MAX_UP)
            up_eff = UP_W'(MAX_UP);
        else
            up_eff = UP_W'(up_reg);

        priority if (down_reg == '0)
            down_eff = DOWN_REG_W'(1);
        else if (32'(down_reg) > MAX_DOWN)
            down_eff = DOWN_REG_W'(MAX_DOWN);
        else
            down_eff = down_reg;

        priority if (taps_reg == '0)
            taps_eff = TAPS_W'(1);
        else if (32'(taps_reg) > MAX_TAPS_PER_PHASE)
            taps_eff = TAPS_W'(MAX_TAPS_PER_PHASE);
        else
            taps_eff = TAPS_W'(taps_reg);
    end

endmodule

[design/prr_ctrl.sv]
// ----------------------------------------------------------------------------
// prr_ctrl
// Controller of the resampler: clearing pass, input word acceptance, pointer
// wrap, and the sequencing of results and taps through the shared MAC.
// ----------------------------------------------------------------------------
module prr_ctrl import prr_pkg::*;
#(
    parameter int MAX_UP             = DEF_MAX_UP,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS_PER_PHASE,
    localparam int UP_W   = $clog2(MAX_UP + 1),
    localparam int TAPS_W = $clog2(MAX_TAPS_PER_PHASE + 1),
    localparam int JW     = (MAX_UP > 1) ? $clog2(MAX_UP) : 1,
    localparam int NW     = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              opcode,
    output logic              s_tready,
    input  logic [UP_W-1:0]   up_eff,
    input  logic [TAPS_W-1:0] taps_eff,
    input  stat_t             stat,
    output cmd_t              cmd,
    output logic [JW-1:0]     j_idx
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_PASS_WAIT,
        ST_MAC,
        ST_DRAIN
    } state_t;

    state_t          state_reg;
    logic            ready_reg;
    logic [NW-1:0]   n_reg;
    logic [JW-1:0]   j_reg;
    logic            accept;
    logic            tap_last;
    logic            res_last;

    assign s_tready = ready_reg;
    assign j_idx    = j_reg;
    assign accept   = s_tvalid && ready_reg;
    assign tap_last = ((TAPS_W + 1)'(n_reg) + (TAPS_W + 1)'(1)) == (TAPS_W + 1)'(taps_eff);
    assign res_last = ((UP_W + 1)'(j_reg) + (UP_W + 1)'(1)) == (UP_W + 1)'(up_eff);

    // Commands decoded from the current state.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load   = accept && (opcode == OP_LOAD);
                cmd.sample = accept && (opcode == OP_SAMPLE);
            end
            ST_WRAP:
            begin
                cmd.mod_sub = stat.mod_ge;
                cmd.commit  = !stat.mod_ge;
            end
            ST_PASS_WAIT:
            begin
                cmd.addr_load = 1'b1;
            end
            ST_MAC:
            begin
                cmd.issue    = 1'b1;
                cmd.first    = (n_reg == '0);
                cmd.last_tap = tap_last;
                cmd.last_res = res_last;
            end
            ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // State, ready and the tap and result counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
            n_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (stat.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept && (opcode == OP_SAMPLE))
                    begin
                        state_reg <= ST_WRAP;
                        ready_reg <= 1'b0;
                    end
                end
                ST_WRAP:
                begin
                    if (!stat.mod_ge)
                    begin
                        if (stat.dec_zero)
                        begin
                            state_reg <= ST_PASS_WAIT;
                            j_reg     <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            ready_reg <= 1'b1;
                        end
                    end
                end
                ST_PASS_WAIT:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= ST_MAC;
                        n_reg     <= '0;
                    end
                end
                ST_MAC:
                begin
                    if (tap_last)
                        state_reg <= ST_DRAIN;
                    else
                        n_reg <= n_reg + NW'(1);
                end
                ST_DRAIN:
                begin
                    if (stat.result_done)
                    begin
                        if (res_last)
                        begin
                            state_reg <= ST_IDLE;
                            ready_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_PASS_WAIT;
                            j_reg     <= j_reg + JW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

[design/prr_dp.sv]
// ----------------------------------------------------------------------------
// prr_dp
// Datapath of the resampler: coefficient memory, delay line, pointer and
// decimation state, tap address generators, the pipelined multiply-
// accumulate, rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module prr_dp import prr_pkg::*;
#(
    parameter int MAX_UP             = DEF_MAX_UP,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS_PER_PHASE,
    parameter int COEF_DEPTH         = DEF_COEF_DEPTH,
    parameter int SAMPLE_WIDTH       = DEF_SAMPLE_WIDTH,
    localparam int UP_W   = $clog2(MAX_UP + 1),
    localparam int TAPS_W = $clog2(MAX_TAPS_PER_PHASE + 1),
    localparam int JW     = (MAX_UP > 1) ? $clog2(MAX_UP) : 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    output stat_t                          stat,
    input  logic [JW-1:0]                  j_idx,
    input  logic [UP_W-1:0]                up_eff,
    input  logic [DOWN_REG_W-1:0]          down_eff,
    input  logic [TAPS_W-1:0]              taps_eff,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [CIDX_W-1:0]              coef_index,
    input  logic signed [SAMPLE_WIDTH-1:0] coef_value,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [SAMPLE_WIDTH-1:0]        sample_out,
    output logic                           last_of_run
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int FRAC    = SW - 1;
    localparam int TAPW    = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
    localparam int IDX_W   = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int CI_W    = (MAX_TAPS_PER_PHASE * MAX_UP > 1) ?
                             $clog2(MAX_TAPS_PER_PHASE * MAX_UP) : 1;
    localparam int PROD_W  = 2 * SW;
    localparam int ACC_NAT = PROD_W + $clog2(MAX_TAPS_PER_PHASE + 1);
    localparam int ACC_W   = (ACC_NAT > 64) ? 64 : ACC_NAT;
    localparam int Q_W     = ACC_W + 1 - FRAC;

    localparam logic signed [ACC_W:0] RND  = (ACC_W + 1)'(1) << (FRAC - 1);
    localparam logic signed [Q_W-1:0] Q_HI = {{(Q_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO = {{(Q_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

    // Memory, delay line and stream state.
    logic signed [SW-1:0]     coef_mem [COEF_DEPTH];
    logic signed [SW-1:0]     delay_reg [MAX_TAPS_PER_PHASE];
    logic [IDX_W-1:0]         clr_cnt_reg;
    logic [TAPW-1:0]          wp_reg;
    logic [TAPW:0]            mod_reg;
    logic signed [SW-1:0]     sample_reg;
    logic [DEC_W-1:0]         dec_reg;

    // Tap address generators.
    logic [CI_W-1:0]          ci_reg;
    logic [TAPW-1:0]          idx_reg;
    logic [TAPW:0]            idx_inc;

    // MAC pipeline.
    pipe_t                    s1_reg;
    pipe_t                    s2_reg;
    logic                     done_reg;
    logic                     done_last_reg;
    logic signed [SW-1:0]     coef_rd_reg;
    logic                     inrange_reg;
    logic signed [SW-1:0]     x_reg;
    logic signed [SW-1:0]     coef_eff;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  acc_next;

    // Rounding and output.
    logic signed [ACC_W:0]    rnd_sum;
    logic signed [Q_W-1:0]    q_val;
    logic signed [SW-1:0]     sat_val;
    logic                     out_valid_reg;
    logic signed [SW-1:0]     out_data_reg;
    logic                     out_last_reg;

    // Memory write port, shared by the clearing pass and coefficient loads.
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [SW-1:0]     mem_wdata;

    always_comb
    begin
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.load && (32'(coef_index) < COEF_DEPTH);
            mem_waddr = IDX_W'(coef_index);
            mem_wdata = coef_value;
        end
    end

    // Coefficient memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            coef_mem[mem_waddr] <= mem_wdata;
        coef_rd_reg <= coef_mem[IDX_W'(ci_reg)];
    end

    // Status toward the controller.
    assign stat.clear_last  = (clr_cnt_reg == IDX_W'(COEF_DEPTH - 1));
    assign stat.mod_ge      = (mod_reg >= (TAPW + 1)'(taps_eff));
    assign stat.dec_zero    = (dec_reg == '0);
    assign stat.out_free    = !out_valid_reg;
    assign stat.result_done = done_reg;

    assign idx_inc = (TAPW + 1)'(idx_reg) + (TAPW + 1)'(1);

    // Control state: clearing count, delay line, pointer, decimation count,
    // pipeline flags and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            dec_reg       <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TAPS_PER_PHASE; i++)
                delay_reg[i] <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);

            // The newest sample goes to the wrapped pointer position.
            if (cmd.commit)
            begin
                delay_reg[mod_reg[TAPW-1:0]] <= sample_reg;
                wp_reg <= mod_reg[TAPW-1:0];
                if (dec_reg != '0)
                    dec_reg <= dec_reg - DEC_W'(1);
                else
                    dec_reg <= DEC_W'(down_eff - DOWN_REG_W'(1));
            end

            s1_reg.vld      <= cmd.issue;
            s1_reg.first    <= cmd.first;
            s1_reg.last_tap <= cmd.last_tap;
            s1_reg.last_res <= cmd.last_res;
            s2_reg          <= s1_reg;
            done_reg        <= s2_reg.vld && s2_reg.last_tap;

            if (done_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: pointer wrap, address generators, MAC and output.
    always_ff @(posedge clk)
    begin
        // Pointer wrap: one subtract of the length per cycle.
        if (cmd.sample)
        begin
            sample_reg <= sample_in;
            mod_reg    <= (TAPW + 1)'(wp_reg) + (TAPW + 1)'(taps_eff) - (TAPW + 1)'(1);
        end
        else if (cmd.mod_sub)
        begin
            mod_reg <= mod_reg - (TAPW + 1)'(taps_eff);
        end

        // Coefficient index steps by the phase count, delay index wraps.
        if (cmd.addr_load)
        begin
            ci_reg  <= CI_W'(j_idx);
            idx_reg <= wp_reg;
        end
        else if (cmd.issue)
        begin
            ci_reg  <= ci_reg + CI_W'(up_eff);
            idx_reg <= (idx_inc == (TAPW + 1)'(taps_eff)) ? '0 : idx_inc[TAPW-1:0];
        end

        // Stage one: operands.
        inrange_reg <= (32'(ci_reg) < COEF_DEPTH);
        x_reg       <= delay_reg[idx_reg];

        // Stage two: product.
        prod_reg <= coef_eff * x_reg;

        // Stage three: accumulate.
        if (s2_reg.vld)
            acc_reg <= acc_next;

        // Result into the output register.
        if (done_reg)
        begin
            out_data_reg <= sat_val;
            out_last_reg <= done_last_reg;
        end
        done_last_reg <= s2_reg.last_res;
    end

    assign coef_eff = inrange_reg ? coef_rd_reg : '0;
    assign acc_base = s2_reg.first ? '0 : acc_reg;

    // Accumulator add; saturation at plus or minus 2^62 is only reachable
    // when the natural accumulator width exceeds 63 bits.
    generate
        if (ACC_NAT > 63)
        begin : g_acc_sat
            localparam logic signed [ACC_W:0] LIM_P = (ACC_W + 1)'(1) << 62;
            localparam logic signed [ACC_W:0] LIM_N = -LIM_P;
            logic signed [ACC_W:0] sum;

            assign sum = (ACC_W + 1)'(acc_base) + (ACC_W + 1)'(prod_reg);

            always_comb
            begin
                priority if (sum > LIM_P)
                    acc_next = ACC_W'(LIM_P);
                else if (sum < LIM_N)
                    acc_next = ACC_W'(LIM_N);
                else
                    acc_next = ACC_W'(sum);
            end
        end
        else
        begin : g_acc_plain
            assign acc_next = acc_base + ACC_W'(prod_reg);
        end
    endgenerate

    // Round half up to the sample format, then saturate.
    assign rnd_sum = (ACC_W + 1)'(acc_reg) + RND;
    assign q_val   = rnd_sum[ACC_W:FRAC];

    always_comb
    begin
        priority if (q_val > Q_HI)
            sat_val = {1'b0, {(SW - 1){1'b1}}};
        else if (q_val < Q_LO)
            sat_val = {1'b1, {(SW - 1){1'b0}}};
        else
            sat_val = q_val[SW-1:0];
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = out_data_reg;
    assign last_of_run = out_last_reg;

endmodule

[test/tb_polyphase_rational_resampler_unit.sv]
// ----------------------------------------------------------------------------
// tb_polyphase_rational_resampler_unit
// Self-checking testbench for the polyphase rational resampler. Coefficient
// and sample words go in on the input stream, the registers are set over the
// APB port, and every output word is checked against a predictor of the
// filter held in the testbench.
// ----------------------------------------------------------------------------
module tb_polyphase_rational_resampler_unit import prr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W          = ((2 * DEF_SAMPLE_WIDTH + CIDX_W + 7) / 8) * 8;
    localparam int OUT_W         = ((DEF_SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int UP_MAX        = DEF_MAX_UP;
    localparam int TAPS_MAX      = DEF_MAX_TAPS_PER_PHASE;
    localparam int COEFS         = DEF_COEF_DEPTH;
    localparam int IDLE_PCT      = 15;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PRINT_LIMIT   = 50;

    // One output word as the filter should produce it.
    typedef struct {
        logic [15:0] value;
        logic        last;
    } out_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    // tdata from bit 0: sample_in, coef_index, coef_value, zero fill
    logic [IN_W-1:0]    s_tdata;
    // tuser: opcode
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // tdata from bit 0: sample_out
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tlast;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Filter state as the predictor sees it.
    logic [4:0]         up_reg;
    logic [4:0]         down_reg;
    logic [5:0]         taps_reg;
    logic signed [15:0] tap_line [TAPS_MAX];
    logic signed [15:0] coef_mem [COEFS];
    int                 tap_ptr;
    int                 skip_count;
    out_word_t          pending_outputs [$];

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  cycle_count    = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  src_gaps       = 1'b1;
    bit  sink_gaps      = 1'b1;

    polyphase_rational_resampler_unit DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // A register value of zero acts as one, a value above the maximum as the maximum.
    function automatic int clamp_setting(int raw, int hi);
        if (raw == 0)
            return 1;
        if (raw > hi)
            return hi;
        return raw;
    endfunction

    // Update the filter state for one accepted word and queue its output words.
    function automatic void predict_resampled_outputs(logic op, logic [15:0] smp,
                                                      logic [8:0] cidx, logic [15:0] cval);
        int        up;
        int        down;
        int        taps;
        int        k;
        int        ci;
        longint    acc;
        longint    q;
        out_word_t w;
        if (op == OP_LOAD)
        begin
            if (cidx < COEFS)
                coef_mem[cidx] = cval;
            return;
        end
        up   = clamp_setting(int'(up_reg), UP_MAX);
        down = clamp_setting(int'(down_reg), MAX_DOWN);
        taps = clamp_setting(int'(taps_reg), TAPS_MAX);
        k = (tap_ptr + taps - 1) % taps;
        tap_ptr = k;
        tap_line[k] = smp;
        // Skipped samples only shift the delay line.
        if (skip_count != 0)
        begin
            skip_count = (skip_count - 1) & 15;
            return;
        end
        skip_count = (down - 1) & 15;
        for (int j = 0; j < up; j++)
        begin
            acc = 0;
            for (int n = 0; n < taps; n++)
            begin
                ci = n * up + j;
                if (ci < COEFS)
                    acc += longint'(coef_mem[ci]) * longint'(tap_line[(n + k) % taps]);
            end
            // Round half up from Q2.30 to Q1.15, then saturate.
            q = (acc + 64'sd16384) >>> 15;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            w.value = q[15:0];
            w.last  = (j == up - 1);
            pending_outputs.push_back(w);
        end
    endfunction

    // Sender: random gaps, then offer the word until it is taken.
    task automatic send_word(logic op, logic [15:0] smp, logic [8:0] cidx, logic [15:0] cval);
        while (src_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - 41){1'b0}}, cval, cidx, smp};
        do @(posedge clk); while (!s_tready);
        predict_resampled_outputs(op, smp, cidx, cval);
        words_sent++;
    endtask

    task automatic send_sample(logic [15:0] smp);
        send_word(OP_SAMPLE, smp, 9'($urandom), 16'($urandom));
    endtask

    task automatic send_load(logic [8:0] cidx, logic [15:0] cval);
        send_word(OP_LOAD, 16'($urandom), cidx, cval);
    endtask

    // Stop sending, wait for every queued word, then let the block go idle.
    task automatic drain_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_UP_FACTOR:   up_reg   = value[4:0];
            REG_DOWN_FACTOR: down_reg = value[4:0];
            REG_TAPS:        taps_reg = value[5:0];
            default:         ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(reg_idx_t idx, logic [PDATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register %s read %h, want %h", idx.name(), prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all three registers and read them back.
    task automatic set_config(int up, int down, int taps);
        apb_write(REG_UP_FACTOR, PDATA_W'(up));
        apb_write(REG_DOWN_FACTOR, PDATA_W'(down));
        apb_write(REG_TAPS, PDATA_W'(taps));
        apb_read_check(REG_UP_FACTOR, PDATA_W'(up_reg));
        apb_read_check(REG_DOWN_FACTOR, PDATA_W'(down_reg));
        apb_read_check(REG_TAPS, PDATA_W'(taps_reg));
    endtask

    // Sample values with the extremes and small values weighted up.
    function automatic logic [15:0] rand_q15();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'(int'($urandom_range(128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Coefficients mostly of moderate size so that sums do not all saturate.
    function automatic logic [15:0] rand_coef();
        if ($urandom_range(3) == 0)
            return rand_q15();
        return 16'(int'($urandom_range(8191)) - 4096);
    endfunction

    // Register value: mostly small, sometimes zero, the cap or above it.
    function automatic int pick_setting(int common_hi, int cap, int field_max);
        case ($urandom_range(9))
            0:       return 0;
            1:       return cap;
            2:       return $urandom_range(field_max, cap + 1);
            default: return $urandom_range(common_hi, 1);
        endcase
    endfunction

    // Receiver: random stalls, and a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
    end

    // Compare each output word with the oldest queued prediction.
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
            else
            begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("sample_out %h, want %h", m_tdata, want.value));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run %b, want %b", m_tlast, want.last));
            end
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Registers read back their reset values; an empty filter gives zero.
    task automatic test_after_reset();
        apb_read_check(REG_UP_FACTOR, 1);
        apb_read_check(REG_DOWN_FACTOR, 1);
        apb_read_check(REG_TAPS, 1);
        send_sample(16'h7FFF);
        drain_outputs();
    endtask

    // Full-scale coefficients and samples, including the one product that saturates.
    task automatic test_extremes();
        set_config(1, 1, 4);
        send_load(9'd0, 16'h8000);
        send_load(9'd1, 16'h7FFF);
        send_load(9'd2, 16'h4000);
        send_load(9'd3, 16'h0001);
        send_load(9'd511, 16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        drain_outputs();
    endtask

    // Sums exactly half an output step away from a boundary round upward.
    task automatic test_rounding();
        set_config(1, 1, 1);
        send_load(9'd0, 16'h4000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0003);
        send_sample(16'hFFFD);
        drain_outputs();
    endtask

    // Zero and oversized register values, and a shorter delay line mid-stream.
    task automatic test_register_edges();
        set_config(0, 0, 0);
        send_sample(rand_q15());
        send_sample(rand_q15());
        drain_outputs();
        set_config(2, 1, 63);
        send_sample(rand_q15());
        send_sample(rand_q15());
        drain_outputs();
        set_config(2, 1, 3);
        send_sample(rand_q15());
        send_sample(rand_q15());
        drain_outputs();
        set_config(31, 31, 63);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain_outputs();
    endtask

    // The receiver holds off while samples keep coming, so the input stalls.
    task automatic test_backpressure();
        set_config(4, 1, 3);
        hold_request = HOLD_CYCLES;
        repeat (12) send_sample(rand_q15());
        drain_outputs();
    endtask

    // Phases of coefficient sets followed by samples, with some stray loads.
    task automatic test_random_phases();
        int phase;
        int n_coef;
        int goal;
        phase = 0;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal)
        begin
            src_gaps  = (phase != 2);
            sink_gaps = (phase != 2);
            case (phase)
                1:       set_config(16, 16, 32);
                3:       set_config(1, 1, 1);
                default: set_config(pick_setting(4, UP_MAX, 31), pick_setting(3, MAX_DOWN, 31),
                                    pick_setting(8, TAPS_MAX, 63));
            endcase
            n_coef = clamp_setting(int'(up_reg), UP_MAX) * clamp_setting(int'(taps_reg), TAPS_MAX);
            if (n_coef <= 24)
            begin
                for (int i = 0; i < n_coef; i++)
                    send_load(9'(i), rand_coef());
            end
            else
                repeat (16) send_load(9'($urandom_range(n_coef - 1)), rand_coef());
            repeat (20)
            begin
                if ($urandom_range(9) == 0)
                    send_load(9'($urandom_range(COEFS - 1)), rand_q15());
                else
                    send_sample(rand_q15());
            end
            drain_outputs();
            phase++;
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_SAMPLE;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        up_reg     = 5'd1;
        down_reg   = 5'd1;
        taps_reg   = 6'd1;
        tap_ptr    = 0;
        skip_count = 0;
        for (int i = 0; i < TAPS_MAX; i++)
            tap_line[i] = '0;
        for (int i = 0; i < COEFS; i++)
            coef_mem[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_extremes();
        test_rounding();
        test_register_edges();
        test_backpressure();
        test_random_phases();
        drain_outputs();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
